// ----- design/int4_block_dequant_dot_product_defines.svh -----
// Assertion macros shared by the checker of the int4 block dequant dot product.
`ifndef INT4_BLOCK_DEQUANT_DOT_PRODUCT_DEFINES_SVH
`define INT4_BLOCK_DEQUANT_DOT_PRODUCT_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define I4DQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define I4DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/i4dq_pkg.sv -----
// Package with widths and types of the int4 block dequant dot product.
`default_nettype none

package i4dq_pkg;

    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int ELEM_W = 16;
    // A signed nibble times a Q4.11 element fits in 20 bits.
    localparam int PROD_W = NIB_W + ELEM_W;
    // Sum of the two lane products of one byte.
    localparam int PAIR_W = PROD_W + 1;
    localparam int ROW_W  = 48;

    // Control that travels alongside the payload of one pipeline stage.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ----- design/i4dq_if.sv -----
// Channel interfaces: the weight feed and the row result.
`default_nettype none

interface i4dq_feed_if;
    logic                                     valid;
    logic                                     ready;
    logic        [i4dq_pkg::BYTE_W-1:0]       weight_byte;
    logic signed [i4dq_pkg::ELEM_W-1:0]       vec_even;
    logic signed [i4dq_pkg::ELEM_W-1:0]       vec_odd;
    logic signed [i4dq_pkg::ELEM_W-1:0]       block_scale;
    logic                                     last_in_row;

    modport source (
        output valid, weight_byte, vec_even, vec_odd, block_scale, last_in_row,
        input  ready
    );
    modport sink (
        input  valid, weight_byte, vec_even, vec_odd, block_scale, last_in_row,
        output ready
    );
endinterface

interface i4dq_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [i4dq_pkg::ROW_W-1:0]   row_sum;

    modport source (
        output valid, row_sum,
        input  ready
    );
    modport sink (
        input  valid, row_sum,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/i4dq_lane.sv -----
// One multiply lane: offset nibble times a Q4.11 vector element, registered.
`default_nettype none

module i4dq_lane (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic        [i4dq_pkg::NIB_W-1:0]    nibble,
    input  logic signed [i4dq_pkg::ELEM_W-1:0]   element,
    output logic signed [i4dq_pkg::PROD_W-1:0]   product
);

    logic signed [i4dq_pkg::NIB_W-1:0]  weight;
    logic signed [i4dq_pkg::PROD_W-1:0] product_next;
    logic signed [i4dq_pkg::PROD_W-1:0] product_reg;

    // Subtracting 8 from an unsigned nibble is the same as flipping its top bit.
    assign weight       = {~nibble[i4dq_pkg::NIB_W-1], nibble[i4dq_pkg::NIB_W-2:0]};
    assign product_next = weight * element;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ----- design/i4dq_block_acc.sv -----
// Merge stage: adds the lane products into the block sum and closes blocks.
`default_nettype none

module i4dq_block_acc #(
    parameter int BLOCK_BYTES = 16,
    parameter int BLK_W       = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  i4dq_pkg::stage_ctl_t                 lane_ctl,
    input  logic signed [i4dq_pkg::PROD_W-1:0]   prod_even,
    input  logic signed [i4dq_pkg::PROD_W-1:0]   prod_odd,
    input  logic signed [i4dq_pkg::ELEM_W-1:0]   lane_scale,
    output i4dq_pkg::stage_ctl_t                 blk_ctl,
    output logic signed [BLK_W-1:0]              blk_sum,
    output logic signed [i4dq_pkg::ELEM_W-1:0]   blk_scale
);

    localparam int CNT_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BLOCK_BYTES - 1);

    logic signed [i4dq_pkg::PAIR_W-1:0]  pair_sum;
    logic signed [BLK_W-1:0]             acc_sum;
    logic                                close;

    logic signed [BLK_W-1:0]             block_acc_reg;
    logic        [CNT_W-1:0]             byte_cnt_reg;
    i4dq_pkg::stage_ctl_t                blk_ctl_reg;
    i4dq_pkg::stage_ctl_t                blk_ctl_next;
    logic signed [BLK_W-1:0]             blk_sum_reg;
    logic signed [i4dq_pkg::ELEM_W-1:0]  blk_scale_reg;

    assign pair_sum = i4dq_pkg::PAIR_W'(prod_even) + i4dq_pkg::PAIR_W'(prod_odd);
    assign acc_sum  = block_acc_reg + BLK_W'(pair_sum);
    // A row end also closes a partial block.
    assign close    = lane_ctl.valid && (lane_ctl.last || (byte_cnt_reg == LAST_IDX));

    always_comb
    begin
        blk_ctl_next.valid = close;
        blk_ctl_next.last  = lane_ctl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_acc_reg <= '0;
            byte_cnt_reg  <= '0;
            blk_ctl_reg   <= '0;
        end
        else if (en)
        begin
            blk_ctl_reg <= blk_ctl_next;
            if (close)
            begin
                block_acc_reg <= '0;
                byte_cnt_reg  <= '0;
            end
            else if (lane_ctl.valid)
            begin
                block_acc_reg <= acc_sum;
                byte_cnt_reg  <= byte_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && close)
        begin
            blk_sum_reg   <= acc_sum;
            blk_scale_reg <= lane_scale;
        end
    end

    assign blk_ctl   = blk_ctl_reg;
    assign blk_sum   = blk_sum_reg;
    assign blk_scale = blk_scale_reg;

endmodule

`default_nettype wire

// ----- design/i4dq_row_acc.sv -----
// Scales closed blocks, accumulates the row with saturation, holds the result.
`default_nettype none

module i4dq_row_acc #(
    parameter int BLK_W = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  i4dq_pkg::stage_ctl_t                 blk_ctl,
    input  logic signed [BLK_W-1:0]              blk_sum,
    input  logic signed [i4dq_pkg::ELEM_W-1:0]   blk_scale,
    input  logic                                 out_ready,
    output logic                                 hold,
    output logic                                 out_valid,
    output logic signed [i4dq_pkg::ROW_W-1:0]    row_sum
);

    localparam int MUL_W = BLK_W + i4dq_pkg::ELEM_W;
    localparam int SUM_W = i4dq_pkg::ROW_W + 1;
    localparam logic signed [i4dq_pkg::ROW_W-1:0] ROW_MAX =
        {1'b0, {(i4dq_pkg::ROW_W-1){1'b1}}};
    localparam logic signed [i4dq_pkg::ROW_W-1:0] ROW_MIN =
        {1'b1, {(i4dq_pkg::ROW_W-1){1'b0}}};

    i4dq_pkg::stage_ctl_t               mul_ctl_reg;
    logic signed [MUL_W-1:0]            mul_prod_reg;
    logic signed [SUM_W-1:0]            row_wide;
    logic signed [i4dq_pkg::ROW_W-1:0]  row_sat;
    logic                               load;
    logic                               out_valid_next;

    logic signed [i4dq_pkg::ROW_W-1:0]  row_acc_reg;
    logic                               out_valid_reg;
    logic signed [i4dq_pkg::ROW_W-1:0]  row_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_ctl_reg <= '0;
        end
        else if (en)
        begin
            mul_ctl_reg <= blk_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_prod_reg <= blk_sum * blk_scale;
        end
    end

    assign row_wide = SUM_W'(row_acc_reg) + SUM_W'(mul_prod_reg);

    // The sum left the 48-bit range when its two top bits disagree.
    always_comb
    begin
        if (row_wide[SUM_W-1] != row_wide[SUM_W-2])
        begin
            row_sat = row_wide[SUM_W-1] ? ROW_MIN : ROW_MAX;
        end
        else
        begin
            row_sat = row_wide[i4dq_pkg::ROW_W-1:0];
        end
    end

    // A row result may only move forward once the output register is free.
    assign hold = mul_ctl_reg.valid && mul_ctl_reg.last && out_valid_reg && !out_ready;
    assign load = en && mul_ctl_reg.valid && mul_ctl_reg.last;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (en && mul_ctl_reg.valid)
            begin
                row_acc_reg <= mul_ctl_reg.last ? '0 : row_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_sum_reg <= row_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_sum   = row_sum_reg;

endmodule

`default_nettype wire

// ----- design/int4_block_dequant_dot_product.sv -----
// Top level of the int4 block dequant dot product (one GEMV row at a time).
//
//   channel   modport   carries
//   feed      sink      weight_byte, vec_even, vec_odd, block_scale, last_in_row
//   result    source    row_sum
//
// One item is taken every cycle unless frozen; two multiply lanes handle the nibbles.
// A row's last item passes the lane, block and product registers, then the output register.
// The pipeline freezes only while a finished row waits on a full output register.
// Reset clears the block and row sums; no clearing pass is needed.
`default_nettype none

module int4_block_dequant_dot_product #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    i4dq_feed_if.sink            feed,
    i4dq_result_if.source        result
);

    localparam int BLK_W = i4dq_pkg::PAIR_W + $clog2(BLOCK_BYTES);

    logic                                en;
    logic                                hold;
    logic signed [i4dq_pkg::PROD_W-1:0]  prod_even;
    logic signed [i4dq_pkg::PROD_W-1:0]  prod_odd;
    i4dq_pkg::stage_ctl_t                lane_ctl_reg;
    i4dq_pkg::stage_ctl_t                lane_ctl_next;
    logic signed [i4dq_pkg::ELEM_W-1:0]  lane_scale_reg;
    i4dq_pkg::stage_ctl_t                blk_ctl;
    logic signed [BLK_W-1:0]             blk_sum;
    logic signed [i4dq_pkg::ELEM_W-1:0]  blk_scale;

    assign en         = !hold;
    assign feed.ready = en;

    i4dq_lane u_lane_even (
        .clk     (clk),
        .en      (en),
        .nibble  (feed.weight_byte[i4dq_pkg::NIB_W-1:0]),
        .element (feed.vec_even),
        .product (prod_even)
    );

    i4dq_lane u_lane_odd (
        .clk     (clk),
        .en      (en),
        .nibble  (feed.weight_byte[i4dq_pkg::BYTE_W-1:i4dq_pkg::NIB_W]),
        .element (feed.vec_odd),
        .product (prod_odd)
    );

    always_comb
    begin
        lane_ctl_next.valid = feed.valid;
        lane_ctl_next.last  = feed.last_in_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_ctl_reg <= '0;
        end
        else if (en)
        begin
            lane_ctl_reg <= lane_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_scale_reg <= feed.block_scale;
        end
    end

    i4dq_block_acc #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLK_W       (BLK_W)
    ) u_block_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .lane_ctl   (lane_ctl_reg),
        .prod_even  (prod_even),
        .prod_odd   (prod_odd),
        .lane_scale (lane_scale_reg),
        .blk_ctl    (blk_ctl),
        .blk_sum    (blk_sum),
        .blk_scale  (blk_scale)
    );

    i4dq_row_acc #(
        .BLK_W (BLK_W)
    ) u_row_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .blk_ctl   (blk_ctl),
        .blk_sum   (blk_sum),
        .blk_scale (blk_scale),
        .out_ready (result.ready),
        .hold      (hold),
        .out_valid (result.valid),
        .row_sum   (result.row_sum)
    );

endmodule

`default_nettype wire

// ----- design/i4dq_checker.sv -----
// Port-level checker for the int4 block dequant dot product, with its bind.
`default_nettype none

`include "int4_block_dequant_dot_product_defines.svh"

module i4dq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                feed_valid,
    input logic                                feed_ready,
    input logic                                feed_last,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [i4dq_pkg::ROW_W-1:0]   result_row_sum
);

    // Rows in flight: at most one per pipeline stage plus the output register.
    localparam logic [2:0] PEND_MAX = 3'd4;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       row_in;
    logic       row_out;

    assign row_in  = feed_valid && feed_ready && feed_last;
    assign row_out = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (row_in && !row_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!row_in && row_out)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `I4DQ_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(result_row_sum), "stalled row result changed")
    `I4DQ_ASSERT_ALWAYS(a_result_has_row, !result_valid || (pending_reg != 3'd0), "row result without a row end")
    `I4DQ_ASSERT_ALWAYS(a_pending_bound, pending_reg <= PEND_MAX, "too many rows in flight")
    `I4DQ_ASSERT_ALWAYS(a_stall_cause, feed_ready || (result_valid && !result_ready), "feed stalled without a waiting result")

endmodule

bind int4_block_dequant_dot_product i4dq_checker u_i4dq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .feed_valid     (feed.valid),
    .feed_ready     (feed.ready),
    .feed_last      (feed.last_in_row),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_row_sum (result.row_sum)
);

`default_nettype wire
